// File: rtl/core/rrss_pkg.sv
// Package for the round-robin schedule simulator core.
// Holds payload structs, the sequencer state type and fixed constants.
// No dependencies.
`default_nettype none
package rrss_pkg;
	localparam int unsigned TIME_W = 23;
	localparam logic [15:0] RESET_QUANTUM = 16'd10;

	typedef struct packed {
		logic [15:0] arrival_time;
		logic [15:0] burst_length;
		logic        last_process;
	} item_t;

	typedef struct packed {
		logic [5:0]        process_id;
		logic [TIME_W-1:0] completion_time;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] wait_time;
		logic              dropped_flag;
		logic              final_result;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SORT,
		ST_SIM_INIT,
		ST_CHECK,
		ST_JUMP,
		ST_ADMIT,
		ST_POP,
		ST_RUN,
		ST_POST_ADMIT,
		ST_FINISH,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

// File: rtl/core/round_robin_schedule_sim_core.sv
// Top level of the round-robin schedule simulator core.
// Depends on rrss_pkg for payload structs and the sequencer state type.
//
//  Channel   Handshake           Payload
//  item      start / busy        item (rrss_pkg::item_t)
//  result    result_valid strobe result (rrss_pkg::result_t)
//  config    cfg_valid/cfg_ready cfg_data (time_quantum, 16 bits)
//
// A loading item is taken in ST_IDLE, then ST_SORT shifts once per entry its
// arrival has to pass in the insertion sort of the arrival order and writes
// the item's index. A dropped item is taken in ST_IDLE alone.
// The last item then starts the simulation, which walks slices through one
// shared comparator: CHECK, POP, RUN, POST_ADMIT and FINISH per slice, with
// JUMP and ADMIT ahead of POP when the clock jumps to the next arrival.
// Busy is high over the whole simulation.
// Reset is asynchronous and active low; stores are not cleared. Each result
// is shown for one cycle and the receiver cannot stall it.
`default_nettype none
module round_robin_schedule_sim_core #(
	parameter int unsigned MAX_PROCS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire rrss_pkg::item_t  item,
	output logic                  result_valid,
	output rrss_pkg::result_t     result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [15:0]      cfg_data
);
	import rrss_pkg::*;

	localparam int unsigned IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int unsigned CW = $clog2(MAX_PROCS + 1);

	// Per-process stores by load order; ord_mem by rank, ring_mem by slot.
	logic [15:0] arr_mem [MAX_PROCS];
	logic [15:0] bur_mem [MAX_PROCS];
	logic [15:0] rem_mem [MAX_PROCS];
	logic [IW-1:0] ord_mem [MAX_PROCS];
	logic [IW-1:0] ring_mem [MAX_PROCS];

	state_t state_q, state_d;
	logic [15:0] quantum_q;
	logic [CW-1:0] loaded_q, admit_q, done_q, fill_q, pos_q;
	logic [IW-1:0] head_q, tail_q, cur_q;
	logic [TIME_W-1:0] time_q;
	logic ovf_q, last_q;
	logic [15:0] new_arr_q, cur_rem_q;

	// The one shared comparator: arrival of an entry against a reference value.
	logic [IW-1:0] cmp_id;
	logic [TIME_W-1:0] cmp_ref;
	logic cmp_gt;

	function automatic logic [IW-1:0] inc_wrap(input logic [IW-1:0] v);
		return (32'(v) + 1 >= MAX_PROCS) ? '0 : IW'(32'(v) + 1);
	endfunction

	assign cfg_ready = (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);

	logic [IW-1:0] pos_idx, pos_m1, adm_idx;
	assign pos_idx = pos_q[IW-1:0];
	assign pos_m1 = IW'(pos_q - 1'b1);
	assign adm_idx = admit_q[IW-1:0];

	always_comb begin
		cmp_id = ord_mem[pos_m1];
		cmp_ref = TIME_W'(new_arr_q);
		if (state_q != ST_SORT) begin
			cmp_id = ord_mem[adm_idx];
			cmp_ref = time_q;
		end
		cmp_gt = TIME_W'(arr_mem[cmp_id]) > cmp_ref;
	end

	logic [15:0] run_len;
	logic [15:0] q_eff;
	assign q_eff = (quantum_q == 16'd0) ? 16'd1 : quantum_q;
	assign run_len = (cur_rem_q < q_eff) ? cur_rem_q : q_eff;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (32'(loaded_q) < MAX_PROCS) state_d = ST_SORT;
					else if (item.last_process) state_d = ST_SIM_INIT;
				end
			end
			ST_SORT: begin
				if (pos_q == '0 || !cmp_gt) state_d = last_q ? ST_SIM_INIT : ST_IDLE;
			end
			ST_SIM_INIT: state_d = (loaded_q == '0) ? ST_DONE : ST_CHECK;
			ST_CHECK: begin
				if (done_q == loaded_q) state_d = ST_DONE;
				else if (fill_q == '0) state_d = ST_JUMP;
				else state_d = ST_POP;
			end
			ST_JUMP: state_d = ST_ADMIT;
			ST_ADMIT: begin
				if (admit_q == loaded_q || cmp_gt) state_d = ST_POP;
			end
			ST_POP: state_d = ST_RUN;
			ST_RUN: state_d = ST_POST_ADMIT;
			ST_POST_ADMIT: begin
				if (admit_q == loaded_q || cmp_gt) state_d = ST_FINISH;
			end
			ST_FINISH: state_d = ST_CHECK;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			quantum_q <= RESET_QUANTUM;
			loaded_q <= '0;
			admit_q <= '0;
			done_q <= '0;
			fill_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			time_q <= '0;
			ovf_q <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			result_valid <= 1'b0;
			if (cfg_valid && cfg_ready) quantum_q <= cfg_data;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						last_q <= item.last_process;
						new_arr_q <= item.arrival_time;
						pos_q <= loaded_q;
						if (32'(loaded_q) < MAX_PROCS) begin
							arr_mem[loaded_q[IW-1:0]] <= item.arrival_time;
							bur_mem[loaded_q[IW-1:0]] <= item.burst_length;
							rem_mem[loaded_q[IW-1:0]] <= item.burst_length;
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_SORT: begin
					if (pos_q != '0 && cmp_gt) begin
						ord_mem[pos_idx] <= ord_mem[pos_m1];
						pos_q <= pos_q - 1'b1;
					end else begin
						ord_mem[pos_idx] <= loaded_q[IW-1:0];
						loaded_q <= loaded_q + 1'b1;
					end
				end
				ST_SIM_INIT: begin
					head_q <= '0;
					tail_q <= '0;
					fill_q <= '0;
					admit_q <= '0;
					done_q <= '0;
					time_q <= '0;
				end
				ST_JUMP: begin
					if (cmp_gt) time_q <= TIME_W'(arr_mem[cmp_id]);
				end
				ST_ADMIT, ST_POST_ADMIT: begin
					if (admit_q != loaded_q && !cmp_gt) begin
						ring_mem[tail_q] <= cmp_id;
						tail_q <= inc_wrap(tail_q);
						fill_q <= fill_q + 1'b1;
						admit_q <= admit_q + 1'b1;
					end
				end
				ST_POP: begin
					cur_q <= ring_mem[head_q];
					cur_rem_q <= rem_mem[ring_mem[head_q]];
					head_q <= inc_wrap(head_q);
					fill_q <= fill_q - 1'b1;
				end
				ST_RUN: begin
					time_q <= time_q + TIME_W'(run_len);
					cur_rem_q <= cur_rem_q - run_len;
					rem_mem[cur_q] <= cur_rem_q - run_len;
				end
				ST_FINISH: begin
					if (cur_rem_q != 16'd0) begin
						ring_mem[tail_q] <= cur_q;
						tail_q <= inc_wrap(tail_q);
						fill_q <= fill_q + 1'b1;
					end else begin
						done_q <= done_q + 1'b1;
						result_valid <= 1'b1;
						result.process_id <= 6'(cur_q);
						result.completion_time <= time_q;
						result.turnaround <= time_q - TIME_W'(arr_mem[cur_q]);
						result.wait_time <= time_q - TIME_W'(arr_mem[cur_q])
							- TIME_W'(bur_mem[cur_q]);
						result.dropped_flag <= ovf_q;
						result.final_result <= (done_q + 1'b1 == loaded_q);
					end
				end
				ST_DONE: begin
					loaded_q <= '0;
					ovf_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: tb/sv/round_robin_schedule_sim_core_tb.sv
// Testbench for round_robin_schedule_sim_core: loads process sets, runs the
// schedule and checks every completion against a round-robin predictor.
// Depends on rrss_pkg and the core RTL.
`default_nettype none
module round_robin_schedule_sim_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rrss_pkg::*;

	localparam int unsigned CAPACITY = 16;
	localparam logic [22:0] TMASK = 23'h7FFFFF;

	// The scoreboard keeps a copy of the process set being loaded. When the
	// closing item of a set arrives, it runs the schedule and queues every
	// completion in the order the block must report it.
	class sched_scoreboard;
		logic [15:0] arr_q[$];
		logic [15:0] burst_q[$];
		bit          dropped;
		logic [15:0] quantum;
		result_t     completions[$];
		int          errors;

		function new();
			quantum = RESET_QUANTUM;
			dropped = 0;
			errors = 0;
		endfunction

		// Notes one accepted item; the closing item runs the whole schedule.
		function void note_item(item_t it);
			int          order[$];
			int          ring[$];
			int unsigned rem[CAPACITY];
			int unsigned q, t, run, pos, admit, done, id, tat, n;
			result_t     r;
			if (arr_q.size() >= CAPACITY) dropped = 1;
			else begin
				arr_q.push_back(it.arrival_time);
				burst_q.push_back(it.burst_length);
			end
			if (!it.last_process) return;
			n = arr_q.size();
			// Stable insertion by arrival: equal arrivals keep load order.
			for (int i = 0; i < n; i++) begin
				pos = order.size();
				while (pos > 0 && arr_q[order[pos-1]] > arr_q[i]) pos--;
				order.insert(pos, i);
				rem[i] = burst_q[i];
			end
			q = (quantum == 0) ? 1 : quantum;
			t = 0;
			admit = 0;
			done = 0;
			while (done < n) begin
				if (ring.size() == 0) begin
					if (arr_q[order[admit]] > t) t = arr_q[order[admit]];
					while (admit < n && arr_q[order[admit]] <= t) begin
						ring.push_back(order[admit]);
						admit++;
					end
				end
				id = ring.pop_front();
				run = (rem[id] < q) ? rem[id] : q;
				t = (t + run) & TMASK;
				rem[id] -= run;
				// Arrivals during the slice go ahead of the requeued process.
				while (admit < n && arr_q[order[admit]] <= t) begin
					ring.push_back(order[admit]);
					admit++;
				end
				if (rem[id] > 0) ring.push_back(id);
				else begin
					done++;
					tat = (t - arr_q[id]) & TMASK;
					r.process_id = id[5:0];
					r.completion_time = t[22:0];
					r.turnaround = tat[22:0];
					r.wait_time = 23'((tat - burst_q[id]) & TMASK);
					r.dropped_flag = dropped;
					r.final_result = (done == n);
					completions.push_back(r);
				end
			end
			arr_q.delete();
			burst_q.delete();
			dropped = 0;
		endfunction

		// Checks one strobed result against the oldest pending completion.
		function void check_result(result_t got);
			result_t want;
			if (completions.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			want = completions.pop_front();
			if (got !== want) begin
				$display("%0t: mismatch expected %p actual %p", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	item_t item = '0;
	logic result_valid;
	result_t result;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;

	sched_scoreboard sb = new();
	bit quiet_stretch;
	int unsigned sent;

	always #5 clk = ~clk;

	round_robin_schedule_sim_core #(.MAX_PROCS(CAPACITY)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result_valid(result_valid), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Results cannot be held off, so every strobe is checked at its edge.
	always @(posedge clk) begin
		if (arst_n && result_valid) sb.check_result(result);
	end

	// Offers one item and waits for its transfer. Random gaps go in first,
	// except during the stretch with no idling. Start stays high into the
	// next item; drain drops it at the end of a set.
	task automatic send_item(input logic [15:0] arr, input logic [15:0] burst,
			input logic last);
		item_t it;
		it.arrival_time = arr;
		it.burst_length = burst;
		it.last_process = last;
		while (!quiet_stretch && $urandom_range(99) < 23) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_item(it);
		sent++;
	endtask

	// Waits for all completions, then lets the sequencer settle back to idle.
	task automatic drain();
		start <= 1'b0;
		while (sb.completions.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Writes the quantum register while the block sits idle.
	task automatic write_quantum(input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.quantum = value;
	endtask

	// One set of processes with random content, mostly short bursts unless wide.
	task automatic random_set(input int n, input bit wide);
		logic [15:0] arr, burst;
		for (int i = 0; i < n; i++) begin
			if (wide || $urandom_range(9) == 0) begin
				arr = 16'($urandom);
				burst = 16'($urandom);
			end else begin
				arr = 16'($urandom_range(60));
				burst = 16'($urandom_range(40));
			end
			send_item(arr, burst, i == n - 1);
		end
	endtask

	initial begin
		quiet_stretch = 0;
		sent = 0;
		repeat (2) @(posedge clk);
		arrival_reset_release: arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset quantum, single process, zero burst, ties, idle gaps.
		send_item(16'd0, 16'd0, 1'b1);
		drain();
		send_item(16'd5, 16'd25, 1'b0);
		send_item(16'd5, 16'd3, 1'b0);
		send_item(16'd0, 16'd12, 1'b0);
		send_item(16'd100, 16'd1, 1'b0);
		send_item(16'd3, 16'd0, 1'b1);
		drain();
		// Extreme fields with the largest quantum.
		write_quantum(16'hFFFF);
		send_item(16'hFFFF, 16'hFFFF, 1'b0);
		send_item(16'd0, 16'hFFFF, 1'b0);
		send_item(16'hFFFF, 16'd1, 1'b1);
		drain();
		// Zero quantum behaves as one; a full set plus overflow on the last item.
		write_quantum(16'd0);
		for (int i = 0; i < CAPACITY + 1; i++)
			send_item(16'(i % 4), 16'(1 + i % 3), i == CAPACITY);
		drain();
		// Smallest legal quantum with large bursts, overflow on the last two items.
		write_quantum(16'd1);
		for (int i = 0; i < CAPACITY + 2; i++)
			send_item(16'(i * 2), (i == 0) ? 16'd0 : 16'(i + 20), i == CAPACITY + 1);
		drain();

		// Random sets, each under a random quantum; one phase without gaps.
		while (sent < 410) begin
			case ($urandom_range(3))
				0: write_quantum(16'($urandom_range(1, 8)));
				1: write_quantum(16'($urandom_range(1, 60)));
				2: write_quantum(16'($urandom));
				default: ;
			endcase
			quiet_stretch = (sent > 200 && sent < 280);
			random_set($urandom_range(1, 20), $urandom_range(7) == 0);
			drain();
		end

		if (sb.errors == 0) $display("round_robin_schedule_sim_core_tb: clean");
		else $display("round_robin_schedule_sim_core_tb: errors");
		$finish;
	end

	// An item with a burst of 65535 under quantum 1 needs about 65535 slices;
	// a run still going at 10 s is ended with errors.
	initial begin
		#10s;
		$display("round_robin_schedule_sim_core_tb: errors");
		$finish;
	end
endmodule
`default_nettype wire
